### rtl/core/mtwr_pkg.sv
// Shared types, command codes and arithmetic helpers for the tile window repacker.
package mtwr_pkg;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // Transfer sequencer phases, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_CASET    = 9'b000000010,
    PH_CA_END   = 9'b000000100,
    PH_CA_START = 9'b000001000,
    PH_RASET    = 9'b000010000,
    PH_RA_LO    = 9'b000100000,
    PH_RA_HI    = 9'b001000000,
    PH_WRITE    = 9'b010000000,
    PH_DATA     = 9'b100000000
  } phase_t;

  localparam logic [7:0] CMD_CASET   = 8'h2A;
  localparam logic [7:0] CMD_RASET   = 8'h2B;
  localparam logic [7:0] CMD_RAMWR   = 8'h2C;
  localparam logic [7:0] COL_MIRROR  = 8'h3C;
  localparam logic [7:0] COL_OFFSET  = 8'h12;
  localparam int         GROUP_COLS  = 12;
  localparam logic [1:0] LAST_PLANE  = 2'd3;

  // What the sequencer produces for the tick that is accepted this cycle.
  typedef struct packed {
    logic       has_result;
    logic       from_ram;
    logic [7:0] byte_val;
    logic       is_cmd;
    logic       last;
    logic [1:0] plane;
  } tick_info_t;

  // Column index divided by twelve: shift by two, then divide by three
  // through the reciprocal 171/512, exact for all 8-bit quotients' inputs.
  function automatic logic [6:0] div12(input logic [9:0] col);
    logic [7:0]  quarter;
    logic [16:0] prod;
    begin
      quarter = col[9:2];
      prod    = {9'd0, quarter} * 17'd171;
      div12   = prod[15:9];
    end
  endfunction

  // Pack one plane (two pixel rows) of four adjacent columns into one byte.
  function automatic logic [7:0] pack_quad(input logic [3:0][7:0] cols,
                                           input logic [1:0] plane);
    logic [7:0] result;
    logic [7:0] shifted;
    begin
      result = 8'd0;
      for (int k = 0; k < 4; k++) begin
        shifted = cols[k] >> {plane, 1'b0};
        result[7 - 2 * k] = shifted[0];
        result[6 - 2 * k] = shifted[1];
      end
      pack_quad = result;
    end
  endfunction

endpackage

### rtl/core/mtwr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mtwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 75
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/mtwr_ctrl.sv
// Draw window latch and transfer sequencer that orders commands, parameters and data.
module mtwr_ctrl #(
  parameter int PANEL_COLUMNS = 300,
  parameter int GROUP_W       = 5,
  parameter int ADDR_W        = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    draw_fire,
  input  logic                    tick_fire,
  input  logic [5:0]              x_tile,
  input  logic [5:0]              tile_count,
  input  logic [5:0]              band,
  output mtwr_pkg::tick_info_t    info,
  output logic [ADDR_W-1:0]       rd_addr
);
  import mtwr_pkg::*;

  phase_t              phase;
  logic [GROUP_W-1:0]  first_group;
  logic [GROUP_W-1:0]  last_group;
  logic [5:0]          band_latched;
  logic [1:0]          plane_index;
  logic [ADDR_W-1:0]   quad_index;
  logic [ADDR_W-1:0]   base_addr;
  logic [ADDR_W-1:0]   last_addr;

  logic [9:0]          start_col;
  logic [9:0]          end_col;
  logic [9:0]          stop_col;
  logic                draw_ok;
  logic [GROUP_W-1:0]  first_group_next;
  logic [GROUP_W-1:0]  last_group_next;
  logic                quad_wrap;

  always_comb begin
    start_col = {1'b0, x_tile, 3'b000};
    end_col   = {({1'b0, x_tile} + {1'b0, tile_count}), 3'b000};
    stop_col  = (end_col > 10'(PANEL_COLUMNS)) ? 10'(PANEL_COLUMNS - 1) : end_col - 10'd1;
    draw_ok   = (tile_count != 6'd0) && (start_col < 10'(PANEL_COLUMNS));
    first_group_next = GROUP_W'(div12(start_col));
    last_group_next  = GROUP_W'(div12(stop_col));
  end

  assign rd_addr   = base_addr + quad_index;
  assign quad_wrap = (rd_addr == last_addr);

  always_comb begin
    info            = '0;
    info.plane      = plane_index;
    unique case (phase)
      PH_IDLE: begin
        info.has_result = 1'b0;
      end
      PH_CASET: begin
        info.has_result = 1'b1;
        info.byte_val   = CMD_CASET;
        info.is_cmd     = 1'b1;
      end
      PH_CA_END: begin
        info.has_result = 1'b1;
        info.byte_val   = COL_MIRROR - (COL_OFFSET + 8'(last_group));
      end
      PH_CA_START: begin
        info.has_result = 1'b1;
        info.byte_val   = COL_MIRROR - (COL_OFFSET + 8'(first_group));
      end
      PH_RASET: begin
        info.has_result = 1'b1;
        info.byte_val   = CMD_RASET;
        info.is_cmd     = 1'b1;
      end
      PH_RA_LO: begin
        info.has_result = 1'b1;
        info.byte_val   = {band_latched, 2'b00};
      end
      PH_RA_HI: begin
        info.has_result = 1'b1;
        info.byte_val   = {band_latched, 2'b11};
      end
      PH_WRITE: begin
        info.has_result = 1'b1;
        info.byte_val   = CMD_RAMWR;
        info.is_cmd     = 1'b1;
      end
      PH_DATA: begin
        info.has_result = 1'b1;
        info.from_ram   = 1'b1;
        info.last       = quad_wrap && (plane_index == LAST_PLANE);
      end
      default: begin
        info.has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      first_group  <= '0;
      last_group   <= '0;
      band_latched <= '0;
      plane_index  <= '0;
      quad_index   <= '0;
      base_addr    <= '0;
      last_addr    <= '0;
    end else if (draw_fire) begin
      if (draw_ok) begin
        phase        <= PH_CASET;
        first_group  <= first_group_next;
        last_group   <= last_group_next;
        band_latched <= band;
        plane_index  <= '0;
        quad_index   <= '0;
        base_addr    <= ADDR_W'({first_group_next, 1'b0}) + ADDR_W'(first_group_next);
        last_addr    <= ADDR_W'({last_group_next, 1'b0}) + ADDR_W'(last_group_next)
                        + ADDR_W'(2);
      end
    end else if (tick_fire) begin
      unique case (phase)
        PH_IDLE:     phase <= PH_IDLE;
        PH_CASET:    phase <= PH_CA_END;
        PH_CA_END:   phase <= PH_CA_START;
        PH_CA_START: phase <= PH_RASET;
        PH_RASET:    phase <= PH_RA_LO;
        PH_RA_LO:    phase <= PH_RA_HI;
        PH_RA_HI:    phase <= PH_WRITE;
        PH_WRITE:    phase <= PH_DATA;
        PH_DATA: begin
          if (quad_wrap) begin
            quad_index <= '0;
            if (plane_index == LAST_PLANE) begin
              plane_index <= '0;
              phase       <= PH_IDLE;
            end else begin
              plane_index <= plane_index + 2'd1;
            end
          end else begin
            quad_index <= quad_index + ADDR_W'(1);
          end
        end
        default:     phase <= PH_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/mono_tile_window_repacker.sv
// Top level of the monochrome tile window repacker: band store banks and output stage.
//
// The block holds one 8-pixel-high band of a monochrome frame, one byte per
// column with bit 0 on top, and turns a draw request into the byte stream of a
// panel transfer: column window command and two mirrored column addresses, row
// window command and two row addresses, memory write command, then four planes
// of packed pixel data, each data byte carrying two pixel rows of four columns.
// Every input beat is a store, a draw request or a tick, and only a tick
// yields an output beat. The band lives in four one-byte-wide RAM banks, one
// per column modulo four, so that the four columns of a data byte are read in
// a single access. Stores, draw requests and command or parameter ticks do not
// hold up the next beat; after a data tick in_ready stays low until the banks
// return the read data, in the cycle after the address.
// After reset the banks are cleared one row per cycle, with in_ready low, over
// all 3*ceil(PANEL_COLUMNS/12) rows (75 at the default width).
// Output beats are held in a register; a new beat is accepted as soon as the
// waiting output beat is being taken.
module mono_tile_window_repacker #(
  parameter int PANEL_COLUMNS = 300
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [8:0] column,
  input  logic [7:0] pixel_byte,
  input  logic [5:0] x_tile,
  input  logic [5:0] tile_count,
  input  logic [5:0] band,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_command,
  output logic       last
);
  import mtwr_pkg::*;

  // Whole 12-column groups cover the panel; each group is three bank rows.
  localparam int NGROUPS = (PANEL_COLUMNS + GROUP_COLS - 1) / GROUP_COLS;
  localparam int DEPTH   = NGROUPS * 3;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int GROUP_W = $clog2(NGROUPS + 1);

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              rd_pending;
  logic              pending_last;
  logic [1:0]        pending_plane;

  logic              fire;
  logic              store_fire;
  logic              draw_fire;
  logic              tick_fire;
  tick_info_t        info;
  logic [ADDR_W-1:0] rd_addr;
  logic [3:0][7:0]   quad_bytes;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  // A new beat waits while the banks are cleared, while a data read is in
  // flight, and while an output beat sits unclaimed.
  assign in_ready   = !clearing && !rd_pending && (!out_valid || out_ready);
  assign fire       = in_valid && in_ready;
  assign store_fire = fire && (kind == KIND_STORE) && ({1'b0, column} < 10'(PANEL_COLUMNS));
  assign draw_fire  = fire && (kind == KIND_DRAW);
  assign tick_fire  = fire && (kind == KIND_TICK);

  assign waddr = clearing ? clr_addr : ADDR_W'(column[8:2]);
  assign wdata = clearing ? 8'd0 : pixel_byte;

  mtwr_ctrl #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .GROUP_W       (GROUP_W),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .draw_fire  (draw_fire),
    .tick_fire  (tick_fire),
    .x_tile     (x_tile),
    .tile_count (tile_count),
    .band       (band),
    .info       (info),
    .rd_addr    (rd_addr)
  );

  // Bank k holds columns 4*row + k. Columns past the panel edge are never
  // written after the clearing pass, so they read as zero.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic bank_we;
    assign bank_we = clearing || (store_fire && (column[1:0] == 2'(k)));

    mtwr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (tick_fire && info.from_ram),
      .raddr (rd_addr),
      .rdata (quad_bytes[k])
    );
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Output register. Command and parameter beats load at the tick itself;
  // data beats load in the cycle after the tick, when the bank read returns.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= tick_fire && info.from_ram;
      if (rd_pending || (tick_fire && info.has_result && !info.from_ram)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_byte   <= pack_quad(quad_bytes, pending_plane);
      is_command <= 1'b0;
      last       <= pending_last;
    end else if (tick_fire && info.has_result && !info.from_ram) begin
      out_byte   <= info.byte_val;
      is_command <= info.is_cmd;
      last       <= 1'b0;
    end
    if (tick_fire && info.from_ram) begin
      pending_plane <= info.plane;
      pending_last  <= info.last;
    end
  end

endmodule

### rtl/core/mtwr_checker.sv
// Port-level checks for the tile window repacker and the bind that attaches them.
module mtwr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_command,
  input logic       last
);
  import mtwr_pkg::*;

  // No output beat appears right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  // A stalled output beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_command)
                                && $stable(last))
    else $error("stalled output beat changed");

  // The final beat of a transfer is always a data byte.
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !is_command)
    else $error("command byte flagged as last");

  // Stores and draw requests never produce an output beat.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind != KIND_TICK) |=> !out_valid)
    else $error("output beat after a non-tick input beat");

endmodule

bind mono_tile_window_repacker mtwr_checker u_mtwr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .is_command (is_command),
  .last       (last)
);
